// ----- hdl/cbcv_pkg.sv -----
package cbcv_pkg;

	localparam int RAW_W     = 16;
	localparam int NORM_W    = 9;
	localparam int CLASS_W   = 3;
	localparam int NBOX      = 5;
	localparam int BOUND_W   = 9;
	localparam int BOX_W     = 6 * BOUND_W;
	localparam int SPV_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_CHAN  = 3;
	localparam int CHAN_W    = 2;
	localparam int STEP_W    = $clog2(NORM_W);

	localparam int NUM_CLASSES_DEF = 5;
	localparam int MAX_SCANS_DEF   = 15;

	localparam logic [NORM_W-1:0]    NORM_MAX    = '1;
	localparam logic [SPV_W-1:0]     SPV_RESET   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPV     = 3'd5;
	localparam logic [CLASS_W-1:0]   CLS_UNKNOWN = 3'd0;
	localparam logic [CHAN_W-1:0]    CHAN_FIRST  = 2'd0;
	localparam logic [CHAN_W-1:0]    CHAN_LAST   = 2'd2;
	localparam logic [STEP_W-1:0]    STEP_LAST   = STEP_W'(NORM_W - 1);

	typedef struct packed {
		logic                load;
		logic                div_init;
		logic                div_step;
		logic                first_step;
		logic                last_step;
		logic [CHAN_W-1:0]   chan;
		logic                classify;
		logic                commit;
	} cbcv_cmd_t;

	typedef struct packed {
		logic [NORM_W-1:0]  red_norm;
		logic [NORM_W-1:0]  green_norm;
		logic [NORM_W-1:0]  blue_norm;
		logic [CLASS_W-1:0] scan_class;
		logic               clear_zero;
		logic               vote_done;
		logic [CLASS_W-1:0] vote_class;
	} cbcv_res_t;

endpackage

// ----- hdl/cbcv_scan_if.sv -----
interface cbcv_scan_if;
	import cbcv_pkg::*;

	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] red_raw;
	logic [RAW_W-1:0] green_raw;
	logic [RAW_W-1:0] blue_raw;
	logic [RAW_W-1:0] clear_raw;

	modport source (output valid, red_raw, green_raw, blue_raw, clear_raw, input ready);
	modport sink   (input valid, red_raw, green_raw, blue_raw, clear_raw, output ready);
endinterface

// ----- hdl/cbcv_result_if.sv -----
interface cbcv_result_if;
	import cbcv_pkg::*;

	logic               valid;
	logic               ready;
	logic [NORM_W-1:0]  red_norm;
	logic [NORM_W-1:0]  green_norm;
	logic [NORM_W-1:0]  blue_norm;
	logic [CLASS_W-1:0] scan_class;
	logic               clear_zero;
	logic               vote_done;
	logic [CLASS_W-1:0] vote_class;

	modport source (output valid, red_norm, green_norm, blue_norm, scan_class, clear_zero,
		vote_done, vote_class, input ready);
	modport sink   (input valid, red_norm, green_norm, blue_norm, scan_class, clear_zero,
		vote_done, vote_class, output ready);
endinterface

// ----- hdl/cbcv_cfg_if.sv -----
interface cbcv_cfg_if;
	import cbcv_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BOX_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/cbcv_ctrl.sv -----
module cbcv_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cbcv_pkg::cbcv_cmd_t  cmd
);
	import cbcv_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INIT   = 3'd1;
	localparam logic [2:0] S_STEP   = 3'd2;
	localparam logic [2:0] S_CLASS  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0]        state_q;
	logic [CHAN_W-1:0] chan_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.chan       = chan_q;
		cmd.first_step = (step_q == '0);
		cmd.last_step  = (step_q == STEP_LAST);
		unique case (state_q)
			S_IDLE:   cmd.load     = in_valid;
			S_INIT:   cmd.div_init = 1'b1;
			S_STEP:   cmd.div_step = 1'b1;
			S_CLASS:  cmd.classify = 1'b1;
			S_COMMIT: cmd.commit   = out_free;
			default:  cmd          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chan_q  <= CHAN_FIRST;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_INIT;
						chan_q  <= CHAN_FIRST;
					end
				end
				S_INIT: begin
					state_q <= S_STEP;
					step_q  <= '0;
				end
				S_STEP: begin
					if (step_q == STEP_LAST) begin
						if (chan_q == CHAN_LAST) begin
							state_q <= S_CLASS;
						end else begin
							chan_q  <= chan_q + 1'b1;
							state_q <= S_INIT;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_CLASS: state_q <= S_COMMIT;
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> out_free)
		else $error("result overwritten before taken");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not raise valid");
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		chan_q == CHAN_FIRST || chan_q == 2'd1 || chan_q == CHAN_LAST)
		else $error("channel select out of range");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |-> (step_q <= STEP_LAST))
		else $error("divider step count overrun");
`endif
endmodule

// ----- hdl/cbcv_dp.sv -----
module cbcv_dp #(
	parameter int NUM_CLASSES = cbcv_pkg::NUM_CLASSES_DEF,
	parameter int MAX_SCANS   = cbcv_pkg::MAX_SCANS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbcv_pkg::cbcv_cmd_t           cmd,
	input  logic [cbcv_pkg::RAW_W-1:0]    red_raw,
	input  logic [cbcv_pkg::RAW_W-1:0]    green_raw,
	input  logic [cbcv_pkg::RAW_W-1:0]    blue_raw,
	input  logic [cbcv_pkg::RAW_W-1:0]    clear_raw,
	input  logic                          cfg_we,
	input  logic [cbcv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbcv_pkg::BOX_W-1:0]    cfg_data,
	output cbcv_pkg::cbcv_res_t           res
);
	import cbcv_pkg::*;

	localparam int CNT_W = $clog2(MAX_SCANS + 1);
	localparam int CMP_W = (CNT_W > SPV_W) ? CNT_W : SPV_W;
	localparam int NHIT  = NUM_CLASSES + 1;

	function automatic logic in_box(input logic [BOX_W-1:0] box,
		input logic [NORM_W-1:0] r, input logic [NORM_W-1:0] g, input logic [NORM_W-1:0] b);
		logic ok;
		ok = (r >= box[0*BOUND_W +: BOUND_W]) && (r <= box[1*BOUND_W +: BOUND_W]) &&
			(g >= box[2*BOUND_W +: BOUND_W]) && (g <= box[3*BOUND_W +: BOUND_W]) &&
			(b >= box[4*BOUND_W +: BOUND_W]) && (b <= box[5*BOUND_W +: BOUND_W]);
		return ok;
	endfunction

	logic [BOX_W-1:0]   box_q [NBOX];
	logic [SPV_W-1:0]   spv_q;
	logic [RAW_W-1:0]   raw_q [NUM_CHAN];
	logic [RAW_W-1:0]   clr_q;
	logic [RAW_W-1:0]   rem_q;
	logic [NORM_W-1:0]  quo_q;
	logic               sat_q;
	logic               lead_q;
	logic [NORM_W-1:0]  norm_q [NUM_CHAN];
	logic [CLASS_W-1:0] cls_q;
	logic [CNT_W-1:0]   hits_q [NHIT];
	logic [CNT_W-1:0]   seen_q;
	cbcv_res_t          res_q;

	logic [RAW_W-1:0]   cur;
	logic [RAW_W:0]     trial;
	logic               ge;
	logic [RAW_W:0]     rem_next;
	logic [NORM_W-1:0]  quo_next;
	logic [CLASS_W-1:0] cls_comb;
	logic [CNT_W-1:0]   hits_new [NHIT];
	logic [CNT_W-1:0]   seen_new;
	logic [CMP_W-1:0]   win_n;
	logic               done;
	logic [CLASS_W-1:0] vote;

	assign cur      = raw_q[cmd.chan];
	assign trial    = {rem_q, cmd.first_step ? lead_q : 1'b0};
	assign ge       = trial >= {1'b0, clr_q};
	assign rem_next = ge ? trial - {1'b0, clr_q} : trial;
	assign quo_next = {quo_q[NORM_W-2:0], ge};

	always_comb begin
		cls_comb = CLS_UNKNOWN;
		for (int i = NBOX - 1; i >= 0; i--) begin
			if (i < NUM_CLASSES && in_box(box_q[i], norm_q[0], norm_q[1], norm_q[2])) begin
				cls_comb = CLASS_W'(i + 1);
			end
		end
		if (clr_q == '0) begin
			cls_comb = CLS_UNKNOWN;
		end
	end

	always_comb begin
		if (spv_q == '0) begin
			win_n = CMP_W'(1);
		end else if (CMP_W'(spv_q) > CMP_W'(MAX_SCANS)) begin
			win_n = CMP_W'(MAX_SCANS);
		end else begin
			win_n = CMP_W'(spv_q);
		end
		seen_new = seen_q + 1'b1;
		done     = CMP_W'(seen_new) >= win_n;
		for (int i = 0; i < NHIT; i++) begin
			hits_new[i] = hits_q[i] + CNT_W'(int'(cls_q) == i);
		end
		vote = CLS_UNKNOWN;
		for (int i = NHIT - 1; i >= 0; i--) begin
			if (CMP_W'(hits_new[i]) > (win_n >> 1)) begin
				vote = CLASS_W'(i);
			end
		end
		if (!done) begin
			vote = CLS_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NBOX; i++) begin
				box_q[i] <= '0;
			end
			spv_q <= SPV_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_SPV) begin
				spv_q <= cfg_data[SPV_W-1:0];
			end else if (cfg_index < REG_SPV) begin
				box_q[cfg_index] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q[0] <= red_raw;
			raw_q[1] <= green_raw;
			raw_q[2] <= blue_raw;
			clr_q    <= clear_raw;
		end
		if (cmd.div_init) begin
			rem_q  <= {1'b0, cur[RAW_W-1:1]};
			lead_q <= cur[0];
			sat_q  <= {1'b0, cur} >= {clr_q, 1'b0};
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_next[RAW_W-1:0];
			quo_q <= quo_next;
			if (cmd.last_step) begin
				norm_q[cmd.chan] <= sat_q ? NORM_MAX : quo_next;
			end
		end
		if (cmd.classify) begin
			cls_q <= cls_comb;
		end
		if (cmd.commit) begin
			res_q.red_norm   <= norm_q[0];
			res_q.green_norm <= norm_q[1];
			res_q.blue_norm  <= norm_q[2];
			res_q.scan_class <= cls_q;
			res_q.clear_zero <= (clr_q == '0);
			res_q.vote_done  <= done;
			res_q.vote_class <= vote;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NHIT; i++) begin
				hits_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (cmd.commit) begin
			for (int i = 0; i < NHIT; i++) begin
				hits_q[i] <= done ? '0 : hits_new[i];
			end
			seen_q <= done ? '0 : seen_new;
		end
	end

	assign res = res_q;

`ifndef SYNTHESIS
	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && done) |=> (seen_q == '0))
		else $error("window count not cleared on vote");
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(seen_q) < CMP_W'(MAX_SCANS))
		else $error("scan count beyond window limit");
	a_zero_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.classify && clr_q == '0) |=> (cls_q == CLS_UNKNOWN))
		else $error("zero clear count classified");
`endif
endmodule

// ----- hdl/color_box_classifier_vote_top.sv -----
// Color box classifier with majority vote.
// scan: one raw sensor item (red, green, blue, clear counts) per handshake.
// result: one item per scan with the three normalized channels, the scan
//   class, the zero-clear flag and, on the last scan of a window, the vote.
// cfg: register writes (index 0..4 class boxes, 5 window length); ready is
//   always high, writes to other indexes are dropped. Write only while idle.
// Each channel is normalized by a shared restoring divider, one quotient
// bit per cycle, nine bits per channel, channels in turn. Scan ready is
// low from an accepted scan until its result is committed to the output
// register, so a new scan is taken only after the last one is through.
// The output register holds a finished result while the receiver stalls;
// the next scan is still accepted and worked through, and waits only to
// load the output register until the previous result is taken.
// Reset clears the boxes, sets the window length to 5 scans and clears
// the hit counts and the window scan count.
module color_box_classifier_vote_top #(
	parameter int NUM_CLASSES = cbcv_pkg::NUM_CLASSES_DEF,
	parameter int MAX_SCANS   = cbcv_pkg::MAX_SCANS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	cbcv_scan_if.sink      scan,
	cbcv_result_if.source  result,
	cbcv_cfg_if.sink       cfg
);
	import cbcv_pkg::*;

	cbcv_cmd_t cmd;
	cbcv_res_t res;

	assign cfg.ready = 1'b1;

	cbcv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scan.valid),
		.in_ready  (scan.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	cbcv_dp #(
		.NUM_CLASSES (NUM_CLASSES),
		.MAX_SCANS   (MAX_SCANS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.red_raw   (scan.red_raw),
		.green_raw (scan.green_raw),
		.blue_raw  (scan.blue_raw),
		.clear_raw (scan.clear_raw),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.res       (res)
	);

	assign result.red_norm   = res.red_norm;
	assign result.green_norm = res.green_norm;
	assign result.blue_norm  = res.blue_norm;
	assign result.scan_class = res.scan_class;
	assign result.clear_zero = res.clear_zero;
	assign result.vote_done  = res.vote_done;
	assign result.vote_class = res.vote_class;
endmodule
